/* rtl/acbm_pkg.sv */
// acbm_pkg: shared widths, command codes and sequencer states of the
// Aho-Corasick bitmap matcher. No dependencies; compile first.
package acbm_pkg;

  // Fixed field widths of the item and result channels
  localparam int CMD_W      = 2;
  localparam int ADDR_W     = 10;
  localparam int BITMAP_W   = 8;
  localparam int PAT_W      = 4;
  localparam int SYM_W      = 3;
  localparam int PID_W      = 3;
  localparam int END_POS_W  = 32;

  // At most this many matches are reported for one symbol
  localparam int MAX_RESULTS = 8;
  localparam int CNT_W       = 4;
  // Popcount of an eight-bit bitmap fits in four bits
  localparam int POP_W       = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_SYMBOL  = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FAIL,
    ST_RED,
    ST_CFETCH,
    ST_NODE,
    ST_FLUSH
  } state_t;

endpackage

/* rtl/acbm_if.sv */
// acbm_in_if / acbm_out_if: valid-ready channels of the matcher.
// Depends on acbm_pkg for the field widths.
interface acbm_in_if;
  logic                                valid;
  logic                                ready;
  logic [acbm_pkg::CMD_W-1:0]          command;
  logic [acbm_pkg::ADDR_W-1:0]         node_address;
  logic [acbm_pkg::BITMAP_W-1:0]       node_bitmap;
  logic [acbm_pkg::ADDR_W-1:0]         node_child_base;
  logic signed [acbm_pkg::PAT_W-1:0]   node_pattern;
  logic [acbm_pkg::ADDR_W-1:0]         node_output_link;
  logic [acbm_pkg::ADDR_W-1:0]         node_fail_link;
  logic [acbm_pkg::SYM_W-1:0]          symbol;

  modport source (output valid, command, node_address, node_bitmap, node_child_base,
                  node_pattern, node_output_link, node_fail_link, symbol,
                  input ready);
  modport sink   (input valid, command, node_address, node_bitmap, node_child_base,
                  node_pattern, node_output_link, node_fail_link, symbol,
                  output ready);
  modport monitor (input valid, ready, command, node_address, node_bitmap,
                   node_child_base, node_pattern, node_output_link, node_fail_link,
                   symbol);
endinterface

interface acbm_out_if;
  logic                               valid;
  logic                               ready;
  logic [acbm_pkg::PID_W-1:0]         pattern_id;
  logic [acbm_pkg::END_POS_W-1:0]     end_position;
  logic                               last_match;

  modport source  (output valid, pattern_id, end_position, last_match, input ready);
  modport sink    (input valid, pattern_id, end_position, last_match, output ready);
  modport monitor (input valid, ready, pattern_id, end_position, last_match);
endinterface

/* rtl/acbm_node_ram.sv */
// acbm_node_ram: single write port, single read port node table with a
// registered read. No dependencies.
module acbm_node_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 42
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read; data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/aho_corasick_bitmap_matcher.sv */
// Aho-Corasick bitmap matcher, top level: sequencer around one node table.
// Depends on acbm_pkg, acbm_if (acbm_in_if, acbm_out_if) and acbm_node_ram.
//
// Items are taken one at a time. A load writes one node entry and a restart
// returns to the root at text position zero. A symbol follows fail links
// until a transition or the root, fetches the child and walks its output
// links, then flushes the final match when it produced any: the single
// read port of the node table is visited once per node on the fail path,
// once for the child and once per output-link node. A symbol with no
// transition returns to idle after the fail walk. When NODE_COUNT is not a
// power of two, table indices are reduced modulo NODE_COUNT by shift-subtract
// from NODE_COUNT << KTOP down, KTOP being the largest shift that keeps
// NODE_COUNT << KTOP within 1023 (zero when NODE_COUNT exceeds 511); this
// is done for the links of a load and for each child index.
// Matches leave through an output register; the next item is accepted while
// the final match waits, and a stalled output holds the sequencer.
module aho_corasick_bitmap_matcher #(
  parameter int NODE_COUNT    = 1024,
  parameter int PATTERN_COUNT = 8,
  parameter int ALPHABET_SIZE = 8,
  parameter int POSITION_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  acbm_in_if.sink    in_ch,
  acbm_out_if.source out_ch
);

  // Largest shift k with NODE_COUNT << k still within a 10-bit link value
  function automatic int red_top(input int n);
    int k;
    k = 0;
    while ((n << (k + 1)) <= 1023) begin
      k++;
    end
    return k;
  endfunction

  localparam int NW      = $clog2(NODE_COUNT);
  localparam int RW      = ((NW > acbm_pkg::ADDR_W) ? NW : acbm_pkg::ADDR_W) + 2;
  localparam int WW      = NW + 1;
  localparam int DW      = 3 * NW + acbm_pkg::BITMAP_W + acbm_pkg::PAT_W;
  localparam bit IS_POW2 = (NODE_COUNT & (NODE_COUNT - 1)) == 0;
  localparam int KTOP    = red_top(NODE_COUNT);
  localparam logic [RW-1:0] DTOP   = RW'(NODE_COUNT << KTOP);
  localparam logic [RW-1:0] NODE_N = RW'(NODE_COUNT);
  localparam logic [WW-1:0] NODE_W = WW'(NODE_COUNT);

  // Entry layout, low to high: fail link, output link, pattern, base, bitmap
  localparam int OL_LO = NW;
  localparam int PT_LO = 2 * NW;
  localparam int BS_LO = 2 * NW + acbm_pkg::PAT_W;
  localparam int BM_LO = 3 * NW + acbm_pkg::PAT_W;

  acbm_pkg::state_t state_r, state_nxt;

  logic [NW-1:0]                    node_r, node_nxt;
  logic [POSITION_BITS-1:0]         text_pos_r, text_pos_nxt;
  logic [acbm_pkg::END_POS_W-1:0]   pos_r, pos_nxt;
  logic [acbm_pkg::SYM_W-1:0]       sym_r, sym_nxt;
  logic [WW-1:0]                    walk_r, walk_nxt;
  logic                             first_r, first_nxt;
  logic [acbm_pkg::CNT_W-1:0]       n_r, n_nxt;
  logic                             pend_v_r, pend_v_nxt;
  logic [acbm_pkg::PID_W-1:0]       pend_pid_r, pend_pid_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [acbm_pkg::PID_W-1:0]       out_pid_r, out_pid_nxt;
  logic [acbm_pkg::END_POS_W-1:0]   out_end_r, out_end_nxt;
  logic                             out_last_r, out_last_nxt;
  logic [RW-1:0]                    lane_r [3];
  logic [RW-1:0]                    lane_nxt [3];
  logic [RW-1:0]                    lane_step [3];
  logic [RW-1:0]                    dv_r, dv_nxt;
  logic                             ret_load_r, ret_load_nxt;
  logic [NW-1:0]                    ld_addr_r, ld_addr_nxt;
  logic [acbm_pkg::BITMAP_W-1:0]    ld_bitmap_r, ld_bitmap_nxt;
  logic [acbm_pkg::PAT_W-1:0]       ld_pat_r, ld_pat_nxt;

  logic          ram_we;
  logic [NW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic          ram_re;
  logic [NW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;

  logic [NW-1:0]                 e_flink;
  logic [NW-1:0]                 e_olink;
  logic [acbm_pkg::PAT_W-1:0]    e_pat;
  logic [NW-1:0]                 e_base;
  logic [acbm_pkg::BITMAP_W-1:0] e_bitmap;

  logic                          in_acc;
  logic                          addr_ok;
  logic                          has_child;
  logic                          pat_ok;
  logic                          out_free;
  logic                          red_done;
  logic [acbm_pkg::POP_W-1:0]    pop_cnt;
  logic [RW-1:0]                 child_idx;

  acbm_node_ram #(
    .DEPTH (NODE_COUNT),
    .AW    (NW),
    .DW    (DW)
  ) u_acbm_node_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Fields of the entry last read
  assign e_flink  = ram_rdata[NW-1:0];
  assign e_olink  = ram_rdata[OL_LO +: NW];
  assign e_pat    = ram_rdata[PT_LO +: acbm_pkg::PAT_W];
  assign e_base   = ram_rdata[BS_LO +: NW];
  assign e_bitmap = ram_rdata[BM_LO +: acbm_pkg::BITMAP_W];

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign addr_ok  = 32'(in_ch.node_address) < NODE_COUNT;
  assign out_free = !out_valid_r || out_ch.ready;

  // Transition test and child offset for the current symbol
  assign has_child = (32'(sym_r) < ALPHABET_SIZE) && e_bitmap[sym_r];

  always_comb begin
    pop_cnt = '0;
    for (int i = 0; i < acbm_pkg::BITMAP_W; i++) begin
      if (3'(i) <= sym_r) begin
        pop_cnt = pop_cnt + acbm_pkg::POP_W'(e_bitmap[i]);
      end
    end
  end

  assign child_idx = RW'(e_base) + RW'(pop_cnt) - RW'(1);

  // Pattern present: non-negative and below the pattern count
  assign pat_ok = !e_pat[acbm_pkg::PAT_W-1] &&
                  (32'(e_pat[acbm_pkg::PAT_W-2:0]) < PATTERN_COUNT);

  // Shift-subtract reduction step, three lanes
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lane_step[i] = (lane_r[i] >= dv_r) ? (lane_r[i] - dv_r) : lane_r[i];
    end
  end

  assign red_done = (dv_r == NODE_N);

  // Sequencer: next state, table access and result hand-off
  always_comb begin
    logic [WW-1:0]             walk_after;
    logic [acbm_pkg::CNT_W-1:0] n_after;

    state_nxt     = state_r;
    node_nxt      = node_r;
    text_pos_nxt  = text_pos_r;
    pos_nxt       = pos_r;
    sym_nxt       = sym_r;
    walk_nxt      = walk_r;
    first_nxt     = first_r;
    n_nxt         = n_r;
    pend_v_nxt    = pend_v_r;
    pend_pid_nxt  = pend_pid_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_pid_nxt   = out_pid_r;
    out_end_nxt   = out_end_r;
    out_last_nxt  = out_last_r;
    for (int i = 0; i < 3; i++) begin
      lane_nxt[i] = lane_r[i];
    end
    dv_nxt        = dv_r;
    ret_load_nxt  = ret_load_r;
    ld_addr_nxt   = ld_addr_r;
    ld_bitmap_nxt = ld_bitmap_r;
    ld_pat_nxt    = ld_pat_r;

    ram_we    = 1'b0;
    ram_waddr = ld_addr_r;
    ram_wdata = {ld_bitmap_r, NW'(lane_step[0]), ld_pat_r,
                 NW'(lane_step[1]), NW'(lane_step[2])};
    ram_re    = 1'b0;
    ram_raddr = node_r;

    walk_after = first_r ? '0 : (walk_r + WW'(1));
    n_after    = pat_ok ? (n_r + acbm_pkg::CNT_W'(1)) : n_r;

    case (state_r)
      acbm_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_ch.command)
            acbm_pkg::CMD_LOAD: begin
              if (addr_ok) begin
                if (IS_POW2) begin
                  // Index width truncation is the modulo here
                  ram_we    = 1'b1;
                  ram_waddr = NW'(in_ch.node_address);
                  ram_wdata = {in_ch.node_bitmap, NW'(in_ch.node_child_base),
                               in_ch.node_pattern, NW'(in_ch.node_output_link),
                               NW'(in_ch.node_fail_link)};
                end else begin
                  ld_addr_nxt   = NW'(in_ch.node_address);
                  ld_bitmap_nxt = in_ch.node_bitmap;
                  ld_pat_nxt    = in_ch.node_pattern;
                  lane_nxt[0]   = RW'(in_ch.node_child_base);
                  lane_nxt[1]   = RW'(in_ch.node_output_link);
                  lane_nxt[2]   = RW'(in_ch.node_fail_link);
                  dv_nxt        = DTOP;
                  ret_load_nxt  = 1'b1;
                  state_nxt     = acbm_pkg::ST_RED;
                end
              end
            end
            acbm_pkg::CMD_SYMBOL: begin
              sym_nxt      = in_ch.symbol;
              pos_nxt      = acbm_pkg::END_POS_W'(text_pos_r);
              text_pos_nxt = text_pos_r + POSITION_BITS'(1);
              walk_nxt     = '0;
              ram_re       = 1'b1;
              ram_raddr    = node_r;
              state_nxt    = acbm_pkg::ST_FAIL;
            end
            acbm_pkg::CMD_RESTART: begin
              node_nxt     = '0;
              text_pos_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      // One fail link per cycle until a transition, the root or the walk limit
      acbm_pkg::ST_FAIL: begin
        if (has_child) begin
          if (IS_POW2) begin
            node_nxt  = NW'(child_idx);
            state_nxt = acbm_pkg::ST_CFETCH;
          end else begin
            lane_nxt[0]  = child_idx;
            lane_nxt[1]  = '0;
            lane_nxt[2]  = '0;
            dv_nxt       = DTOP;
            ret_load_nxt = 1'b0;
            state_nxt    = acbm_pkg::ST_RED;
          end
        end else if ((node_r == '0) || (walk_r == NODE_W)) begin
          // No transition from the root, or an endless chain: skip
          node_nxt  = '0;
          state_nxt = acbm_pkg::ST_IDLE;
        end else begin
          node_nxt  = e_flink;
          walk_nxt  = walk_r + WW'(1);
          ram_re    = 1'b1;
          ram_raddr = e_flink;
        end
      end

      // Indices modulo NODE_COUNT, one bit position per cycle
      acbm_pkg::ST_RED: begin
        for (int i = 0; i < 3; i++) begin
          lane_nxt[i] = lane_step[i];
        end
        dv_nxt = dv_r >> 1;
        if (red_done) begin
          if (ret_load_r) begin
            ram_we    = 1'b1;
            state_nxt = acbm_pkg::ST_IDLE;
          end else begin
            node_nxt  = NW'(lane_step[0]);
            state_nxt = acbm_pkg::ST_CFETCH;
          end
        end
      end

      acbm_pkg::ST_CFETCH: begin
        ram_re    = 1'b1;
        ram_raddr = node_r;
        first_nxt = 1'b1;
        n_nxt     = '0;
        walk_nxt  = '0;
        state_nxt = acbm_pkg::ST_NODE;
      end

      // Child, then one output-link node per cycle unless a stalled output holds
      // it; a new match pushes the previous one out, so the final one can be flagged
      acbm_pkg::ST_NODE: begin
        if (!(pat_ok && pend_v_r && !out_free)) begin
          if (pat_ok) begin
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_pid_nxt   = pend_pid_r;
              out_end_nxt   = pos_r;
              out_last_nxt  = 1'b0;
            end
            pend_v_nxt   = 1'b1;
            pend_pid_nxt = e_pat[acbm_pkg::PID_W-1:0];
          end
          n_nxt = n_after;
          if ((e_olink != '0) && (walk_after < NODE_W) &&
              (n_after < acbm_pkg::CNT_W'(acbm_pkg::MAX_RESULTS))) begin
            ram_re    = 1'b1;
            ram_raddr = e_olink;
            first_nxt = 1'b0;
            walk_nxt  = walk_after;
          end else if (pat_ok || pend_v_r) begin
            state_nxt = acbm_pkg::ST_FLUSH;
          end else begin
            state_nxt = acbm_pkg::ST_IDLE;
          end
        end
      end

      // Final match of the symbol
      acbm_pkg::ST_FLUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pid_nxt   = pend_pid_r;
          out_end_nxt   = pos_r;
          out_last_nxt  = 1'b1;
          pend_v_nxt    = 1'b0;
          state_nxt     = acbm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = acbm_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= acbm_pkg::ST_IDLE;
      node_r      <= '0;
      text_pos_r  <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      node_r      <= node_nxt;
      text_pos_r  <= text_pos_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    sym_r       <= sym_nxt;
    walk_r      <= walk_nxt;
    first_r     <= first_nxt;
    n_r         <= n_nxt;
    pend_pid_r  <= pend_pid_nxt;
    out_pid_r   <= out_pid_nxt;
    out_end_r   <= out_end_nxt;
    out_last_r  <= out_last_nxt;
    for (int i = 0; i < 3; i++) begin
      lane_r[i] <= lane_nxt[i];
    end
    dv_r        <= dv_nxt;
    ret_load_r  <= ret_load_nxt;
    ld_addr_r   <= ld_addr_nxt;
    ld_bitmap_r <= ld_bitmap_nxt;
    ld_pat_r    <= ld_pat_nxt;
  end

  assign in_ch.ready         = (state_r == acbm_pkg::ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.pattern_id   = out_pid_r;
  assign out_ch.end_position = out_end_r;
  assign out_ch.last_match   = out_last_r;

endmodule

/* rtl/acbm_checker.sv */
// acbm_checker: port-level assertions for the matcher, bound to the top level.
// Depends on acbm_pkg, acbm_if and aho_corasick_bitmap_matcher.
module acbm_checker (
  input logic        clk,
  input logic        rst_n,
  acbm_in_if.sink    in_mon,
  acbm_out_if.source out_mon
);

  logic in_acc;
  logic out_acc;

  assign in_acc  = in_mon.valid && in_mon.ready;
  assign out_acc = out_mon.valid && out_mon.ready;

  // No result is shown in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_mon.valid)
    else $error("result valid straight after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_mon.valid && !out_mon.ready |=> out_mon.valid && $stable(out_mon.pattern_id) &&
      $stable(out_mon.end_position) && $stable(out_mon.last_match))
    else $error("stalled result changed");

  // A symbol item leaves the block busy in the cycle after it is taken
  a_sym_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_mon.command == acbm_pkg::CMD_SYMBOL) |=> !in_mon.ready)
    else $error("ready straight after a symbol item");

  // While a symbol still has matches to come, no new item is taken
  a_busy_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_mon.valid && !out_mon.last_match |-> !in_mon.ready)
    else $error("ready while matches of a symbol are outstanding");

  // Matches of one symbol share its end position
  a_same_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && !out_mon.last_match) ##1 out_mon.valid |->
      out_mon.end_position == $past(out_mon.end_position))
    else $error("end position changed within one symbol");

endmodule

bind aho_corasick_bitmap_matcher acbm_checker u_acbm_checker (
  .clk     (clk),
  .rst_n   (rst_n),
  .in_mon  (in_ch),
  .out_mon (out_ch)
);

/* bench/tb_top.sv */
// tb_top: self-checking bench for aho_corasick_bitmap_matcher, with a directed
// node table then random tries, random stalls on both channels and an in-order
// match scoreboard. Depends on acbm_pkg, acbm_if and the matcher RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CMD_W       = acbm_pkg::CMD_W;
  localparam int ADDR_W      = acbm_pkg::ADDR_W;
  localparam int BITMAP_W    = acbm_pkg::BITMAP_W;
  localparam int PAT_W       = acbm_pkg::PAT_W;
  localparam int SYM_W       = acbm_pkg::SYM_W;
  localparam int PID_W       = acbm_pkg::PID_W;
  localparam int END_POS_W   = acbm_pkg::END_POS_W;
  localparam int MAX_RESULTS = acbm_pkg::MAX_RESULTS;

  localparam int NODE_COUNT    = 1024;
  localparam int PATTERN_COUNT = 8;
  localparam int TOTAL_ITEMS   = 380;
  localparam int WALK_LIMIT    = 128;
  localparam int IDLE_PCT      = 11;
  localparam int CALM_FROM     = 2000;
  localparam int CALM_TO       = 4000;
  localparam int SETTLE_CYCLES = 200;

  // Command code with no meaning to the block
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Which copy of the matcher state a call works on
  localparam int PLANNER   = 0;
  localparam int PREDICTOR = 1;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [ADDR_W-1:0]   node_address;
    logic [BITMAP_W-1:0] node_bitmap;
    logic [ADDR_W-1:0]   node_child_base;
    logic [PAT_W-1:0]    node_pattern;
    logic [ADDR_W-1:0]   node_output_link;
    logic [ADDR_W-1:0]   node_fail_link;
    logic [SYM_W-1:0]    symbol;
  } command_t;

  typedef struct packed {
    logic [BITMAP_W-1:0] bitmap;
    logic [ADDR_W-1:0]   child_base;
    logic [PAT_W-1:0]    pattern;
    logic [ADDR_W-1:0]   out_link;
    logic [ADDR_W-1:0]   fail_to;
  } trie_node_t;

  typedef struct packed {
    logic [PID_W-1:0]     pattern_id;
    logic [END_POS_W-1:0] end_position;
    logic                 last_match;
  } match_t;

  logic clk = 1'b0;
  logic rst_n;

  acbm_in_if  in_ch ();
  acbm_out_if out_ch ();

  aho_corasick_bitmap_matcher u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Two copies of the table: one for planning stimulus, one for checking
  trie_node_t           trie      [2][NODE_COUNT];
  bit                   written   [2][NODE_COUNT];
  logic [ADDR_W-1:0]    cur_node  [2];
  logic [END_POS_W-1:0] text_pos  [2];
  match_t               found     [MAX_RESULTS];

  command_t pending_cmds     [$];
  match_t   expected_matches [$];
  int       cmds_planned = 0;
  int       cmds_taken   = 0;
  int       mismatches   = 0;
  int       cycle_cnt    = 0;
  logic     item_taken   = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t ns  ERROR %s", $time, what);
  endtask

  // Append one match unless the pattern is none or the symbol is full
  function automatic void note_match(inout int n, input logic [PAT_W-1:0] pat,
                                     input logic [END_POS_W-1:0] at);
    if ($signed(pat) >= 0 && $signed(pat) < PATTERN_COUNT && n < MAX_RESULTS) begin
      found[n] = '{pattern_id: pat[PID_W-1:0], end_position: at, last_match: 1'b0};
      n++;
    end
  endfunction

  // One command applied to one copy; returns 0 if it read a never-loaded entry
  function automatic bit advance_matcher(input int who, input command_t c,
                                         output int n_res, output int walk_len);
    logic [ADDR_W-1:0]    node;
    logic [ADDR_W-1:0]    link;
    logic [BITMAP_W-1:0]  below;
    logic [END_POS_W-1:0] at;
    int                   steps;
    int                   walked;
    bit                   safe;
    safe = 1'b1;
    n_res = 0;
    walk_len = 0;
    steps = 0;
    walked = 0;
    case (c.command)
      acbm_pkg::CMD_LOAD: begin
        trie[who][c.node_address] = '{c.node_bitmap, c.node_child_base, c.node_pattern,
                                      c.node_output_link, c.node_fail_link};
        written[who][c.node_address] = 1'b1;
      end
      acbm_pkg::CMD_RESTART: begin
        cur_node[who] = '0;
        text_pos[who] = '0;
      end
      acbm_pkg::CMD_SYMBOL: begin
        at = text_pos[who];
        text_pos[who] = text_pos[who] + 1'b1;
        node = cur_node[who];
        safe = written[who][node];
        // fail walk, bounded against link cycles
        while (node != '0 && !trie[who][node].bitmap[c.symbol] && steps < NODE_COUNT) begin
          node = trie[who][node].fail_to;
          safe &= written[who][node];
          steps++;
        end
        if (!trie[who][node].bitmap[c.symbol]) begin
          cur_node[who] = '0;
        end else begin
          below = trie[who][node].bitmap & ({BITMAP_W{1'b1}} >> (BITMAP_W - 1 - int'(c.symbol)));
          node = trie[who][node].child_base + ADDR_W'($countones(below)) - 1'b1;
          safe &= written[who][node];
          cur_node[who] = node;
          note_match(n_res, trie[who][node].pattern, at);
          // dictionary suffix chain
          link = trie[who][node].out_link;
          while (link != '0 && walked < NODE_COUNT && n_res < MAX_RESULTS) begin
            safe &= written[who][link];
            note_match(n_res, trie[who][link].pattern, at);
            link = trie[who][link].out_link;
            walked++;
          end
          if (n_res > 0) found[n_res-1].last_match = 1'b1;
        end
        walk_len = steps + walked;
      end
      default: ;
    endcase
    return safe;
  endfunction

  // Unused fields get random values so every bit toggles
  function automatic command_t random_command(input logic [CMD_W-1:0] cmd);
    command_t c;
    c.command          = cmd;
    c.node_address     = ADDR_W'($urandom);
    c.node_bitmap      = BITMAP_W'($urandom);
    c.node_child_base  = ADDR_W'($urandom);
    c.node_pattern     = PAT_W'($urandom);
    c.node_output_link = ADDR_W'($urandom);
    c.node_fail_link   = ADDR_W'($urandom);
    c.symbol           = SYM_W'($urandom);
    return c;
  endfunction

  function automatic command_t node_load(input int addr, input int bmp, input int base,
                                         input int pat, input int out, input int fail);
    command_t c;
    c = random_command(acbm_pkg::CMD_LOAD);
    c.node_address     = ADDR_W'(addr);
    c.node_bitmap      = BITMAP_W'(bmp);
    c.node_child_base  = ADDR_W'(base);
    c.node_pattern     = PAT_W'(pat);
    c.node_output_link = ADDR_W'(out);
    c.node_fail_link   = ADDR_W'(fail);
    return c;
  endfunction

  function automatic command_t symbol_command(input int s);
    command_t c;
    c = random_command(acbm_pkg::CMD_SYMBOL);
    c.symbol = SYM_W'(s);
    return c;
  endfunction

  function automatic void plan(input command_t c);
    int n;
    int w;
    void'(advance_matcher(PLANNER, c, n, w));
    pending_cmds.insert(pending_cmds.size(), c);
  endfunction

  // Trie node i of a k-node region: children inside the region, fail and
  // output links strictly towards the root so every walk terminates
  function automatic command_t region_node(input int i, input int k);
    int bmp;
    int ones;
    int pat;
    int base;
    int out;
    int fail;
    bmp = 0;
    for (int s = 0; s < BITMAP_W; s++) begin
      if ($urandom_range(99) < 40) bmp |= 1 << s;
    end
    ones = $countones(bmp);
    pat  = ($urandom_range(99) < 75) ? int'($urandom_range(7)) : 16 - int'($urandom_range(8, 1));
    base = (ones == 0) ? int'($urandom) : int'($urandom_range(k - ones, 1));
    out  = (i == 0 || $urandom_range(1) == 0) ? 0 : int'($urandom_range(i - 1, 0));
    fail = (i == 0) ? int'($urandom) : int'($urandom_range(i - 1, 0));
    return node_load(i, bmp, base, pat, out, fail);
  endfunction

  // Mostly follow an existing edge; fall back to a restart if the walk
  // would touch an unloaded entry or run too long
  function automatic void plan_symbol();
    command_t             c;
    logic [BITMAP_W-1:0]  kids;
    logic [ADDR_W-1:0]    kept_node;
    logic [END_POS_W-1:0] kept_pos;
    int                   n;
    int                   w;
    kids = trie[PLANNER][cur_node[PLANNER]].bitmap;
    c = random_command(acbm_pkg::CMD_SYMBOL);
    if (kids != '0 && $urandom_range(99) < 75) begin
      while (!kids[c.symbol]) c.symbol = SYM_W'($urandom);
    end
    kept_node = cur_node[PLANNER];
    kept_pos  = text_pos[PLANNER];
    if (advance_matcher(PLANNER, c, n, w) && w <= WALK_LIMIT) begin
      pending_cmds.insert(pending_cmds.size(), c);
    end else begin
      cur_node[PLANNER] = kept_node;
      text_pos[PLANNER] = kept_pos;
      plan(random_command(acbm_pkg::CMD_RESTART));
    end
  endfunction

  function automatic bit stall_now();
    return (cycle_cnt < CALM_FROM || cycle_cnt >= CALM_TO) && $urandom_range(99) < IDLE_PCT;
  endfunction

  // Driver: new item or idle at the falling edge once the last one is taken
  always @(negedge clk) begin : driver
    command_t c;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || item_taken) begin
      if (pending_cmds.size() != 0 && !stall_now()) begin
        c = pending_cmds.pop_front();
        in_ch.valid            <= 1'b1;
        in_ch.command          <= c.command;
        in_ch.node_address     <= c.node_address;
        in_ch.node_bitmap      <= c.node_bitmap;
        in_ch.node_child_base  <= c.node_child_base;
        in_ch.node_pattern     <= c.node_pattern;
        in_ch.node_output_link <= c.node_output_link;
        in_ch.node_fail_link   <= c.node_fail_link;
        in_ch.symbol           <= c.symbol;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= rst_n && !stall_now();
  end

  // Monitor: check matches in order, predict from each accepted item
  always @(posedge clk) begin : monitor
    command_t c;
    match_t   got;
    match_t   want;
    int       n;
    int       w;
    cycle_cnt  <= cycle_cnt + 1;
    item_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.pattern_id, out_ch.end_position, out_ch.last_match};
      if (expected_matches.size() == 0) begin
        report_mismatch($sformatf("unexpected match: pattern %0d at %0d last %0b",
                                  got.pattern_id, got.end_position, got.last_match));
      end else begin
        want = expected_matches.pop_front();
        if (got.pattern_id !== want.pattern_id)
          report_mismatch($sformatf("pattern_id %0d, expected %0d (position %0d)",
                                    got.pattern_id, want.pattern_id, want.end_position));
        if (got.end_position !== want.end_position)
          report_mismatch($sformatf("end_position %0d, expected %0d",
                                    got.end_position, want.end_position));
        if (got.last_match !== want.last_match)
          report_mismatch($sformatf("last_match %0b, expected %0b (position %0d)",
                                    got.last_match, want.last_match, want.end_position));
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      c = '{in_ch.command, in_ch.node_address, in_ch.node_bitmap, in_ch.node_child_base,
            in_ch.node_pattern, in_ch.node_output_link, in_ch.node_fail_link, in_ch.symbol};
      void'(advance_matcher(PREDICTOR, c, n, w));
      for (int i = 0; i < n; i++) expected_matches.insert(expected_matches.size(), found[i]);
      cmds_taken++;
    end
  end

  initial begin : stimulus
    int target;
    int k;
    int span;
    int r;
    rst_n = 1'b0;
    for (int i = 0; i < 2; i++) begin
      cur_node[i] = '0;
      text_pos[i] = '0;
    end

    // Directed table: root fans out to nodes 1..8; node 1 has all eight
    // children from base 1023, so symbol 0 reaches 1023 and symbol 1 wraps
    // round to the root; 3 and 4 have self output loops, 5 a self fail loop
    plan(random_command(acbm_pkg::CMD_RESTART));
    plan(node_load(0, 8'hFF, 1, -1, 0, 10'h3FF));
    plan(node_load(1, 8'hFF, 1023, 7, 0, 0));
    plan(node_load(2, 8'h00, 0, 0, 1, 0));
    plan(node_load(3, 8'h00, 0, 5, 3, 0));
    plan(node_load(4, 8'h00, 0, -1, 4, 0));
    plan(node_load(5, 8'h00, 0, 1, 0, 5));
    plan(node_load(1023, 8'h00, 0, -8, 2, 1));
    plan(symbol_command(0));   // root -> 1, one match
    plan(symbol_command(0));   // 1 -> 1023, no own pattern, chain 2 then 1
    plan(symbol_command(2));   // fail back to 1, child index wraps to 1
    plan(symbol_command(1));   // child index wraps to the root
    plan(symbol_command(2));   // endless chain on 3, cut at the result limit
    plan(symbol_command(0));   // fail to root, then 1
    plan(random_command(CMD_UNUSED));
    plan(symbol_command(1));
    plan(symbol_command(3));   // endless chain on 4 with no patterns
    plan(symbol_command(4));   // fail to root, then 5
    plan(symbol_command(6));   // fail loop on 5 gives up, symbol skipped
    plan(symbol_command(1));   // root -> 2, two matches
    plan(random_command(acbm_pkg::CMD_RESTART));
    plan(symbol_command(0));

    // Random tries, each followed by a run of text with some noise
    target = TOTAL_ITEMS;
    while (pending_cmds.size() < target) begin
      k = $urandom_range(48, 16);
      plan(random_command(acbm_pkg::CMD_RESTART));
      for (int i = 0; i < k; i++) plan(region_node(i, k));
      span = $urandom_range(70, 30);
      for (int j = 0; j < span && pending_cmds.size() < target; j++) begin
        r = $urandom_range(99);
        if (r < 3) plan(random_command(CMD_UNUSED));
        else if (r < 6) plan(random_command(acbm_pkg::CMD_RESTART));
        else if (r < 11) plan(node_load($urandom_range(NODE_COUNT - 1, 64), $urandom,
                                        $urandom, $urandom, $urandom, $urandom));
        else if (r < 14) plan(region_node($urandom_range(k - 1, 0), k));
        else plan_symbol();
      end
    end
    cmds_planned = pending_cmds.size();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (cmds_taken < cmds_planned || expected_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("aho_corasick_bitmap_matcher: match");
    end else begin
      $display("aho_corasick_bitmap_matcher: mismatch");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #10_000_000;
    $display("aho_corasick_bitmap_matcher: mismatch");
    $finish;
  end

endmodule
